[design/tbts_pkg.sv]
`default_nettype none
package tbts_pkg;

    localparam int COORD_W   = 18;
    localparam int FRAC_W    = 16;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 24;
    localparam int TXY_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 2'd0,
        CFG_TEX_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef logic [TEXEL_W-1:0] t_texel;

    typedef struct packed {
        t_op                operation;
        logic [COORD_W-1:0] coord_u;
        logic [COORD_W-1:0] coord_v;
        logic [TXY_W-1:0]   texel_x;
        logic [TXY_W-1:0]   texel_y;
        t_texel             texel_color;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_out_item;

    // control carried down the coordinate pipeline
    typedef struct packed {
        logic valid;
        logic sample;
        logic wr_en;
    } t_stage_ctl;

    typedef struct packed {
        logic [TXY_W-1:0] x;
        logic [TXY_W-1:0] y;
        t_texel           color;
    } t_wr;

    // a + floor((b - a) * f / 2^16); result always lies between a and b
    function automatic logic [CHAN_W-1:0] lerp(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [FRAC_W-1:0] f);
        logic signed [CHAN_W:0]          d;
        logic signed [CHAN_W+FRAC_W+1:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        return a + p[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

endpackage
`default_nettype wire

[design/tbts_mem.sv]
`default_nettype none
module tbts_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  tbts_pkg::t_texel    i_wdata,
    input  wire [AW-1:0]        i_raddr_a,
    input  wire [AW-1:0]        i_raddr_b,
    output tbts_pkg::t_texel    o_rdata_a,
    output tbts_pkg::t_texel    o_rdata_b
);

    tbts_pkg::t_texel mem [DEPTH];
    tbts_pkg::t_texel r_a;
    tbts_pkg::t_texel r_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold read data while the pipeline is stalled
        if (i_en) begin
            r_a <= mem[i_raddr_a];
            r_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_a;
    assign o_rdata_b = r_b;

endmodule
`default_nettype wire

[design/tbts_coord.sv]
`default_nettype none
module tbts_coord #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  tbts_pkg::t_in_item           i_item,
    input  wire [$clog2(MAX_WIDTH+1)-1:0]  i_width,
    input  wire [$clog2(MAX_HEIGHT+1)-1:0] i_height,
    output tbts_pkg::t_stage_ctl         o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x0,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x1,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_y0,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_y1,
    output logic [tbts_pkg::FRAC_W-1:0]   o_fx,
    output logic [tbts_pkg::FRAC_W-1:0]   o_fy,
    output tbts_pkg::t_wr                o_wr
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = tbts_pkg::COORD_W;
    localparam int FW = tbts_pkg::FRAC_W;

    tbts_pkg::t_stage_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    tbts_pkg::t_wr        r1_wr, r2_wr, r3_wr, r4_wr;
    logic [CW+WW-1:0]     r1_tu;
    logic [CW+HW-1:0]     r1_tv;
    logic [WW:0]          r2_qx;
    logic [HW:0]          r2_qy;
    logic [FW-1:0]        r2_fx, r2_fy, r3_fx, r3_fy, r4_fx, r4_fy;
    logic [XW-1:0]        r3_x0, r4_x0, r4_x1;
    logic [YW-1:0]        r3_y0, r4_y0, r4_y1;

    tbts_pkg::t_stage_ctl n1_ctl;
    logic [WW+1:0]        xi, two_w;
    logic [HW+1:0]        yi, two_h;
    logic [WW:0]          n_qx;
    logic [HW:0]          n_qy;
    logic [XW-1:0]        n_x0, n_x1;
    logic [YW-1:0]        n_y0, n_y1;
    logic [WW-1:0]        nx_inc;
    logic [HW-1:0]        ny_inc;

    always_comb begin
        n1_ctl.valid  = i_valid;
        n1_ctl.sample = (i_item.operation == tbts_pkg::OP_SAMPLE);
        n1_ctl.wr_en  = (32'(i_item.texel_x) < 32'(MAX_WIDTH))
                     && (32'(i_item.texel_y) < 32'(MAX_HEIGHT));

        // the scaled coordinate is below 4 * size: reduce in two steps
        xi    = r1_tu[CW+WW-1:FW];
        yi    = r1_tv[CW+HW-1:FW];
        two_w = {1'b0, i_width, 1'b0};
        two_h = {1'b0, i_height, 1'b0};
        n_qx  = (xi >= two_w) ? (WW+1)'(xi - two_w) : (WW+1)'(xi);
        n_qy  = (yi >= two_h) ? (HW+1)'(yi - two_h) : (HW+1)'(yi);

        n_x0 = (r2_qx >= {1'b0, i_width})  ? XW'(r2_qx - {1'b0, i_width})  : XW'(r2_qx);
        n_y0 = (r2_qy >= {1'b0, i_height}) ? YW'(r2_qy - {1'b0, i_height}) : YW'(r2_qy);

        nx_inc = WW'(r3_x0) + WW'(1);
        ny_inc = HW'(r3_y0) + HW'(1);
        n_x1   = (nx_inc == i_width)  ? '0 : XW'(nx_inc);
        n_y1   = (ny_inc == i_height) ? '0 : YW'(ny_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tu <= (CW+WW)'(i_item.coord_u) * (CW+WW)'(i_width);
            r1_tv <= (CW+HW)'(i_item.coord_v) * (CW+HW)'(i_height);
            r1_wr <= '{x: i_item.texel_x, y: i_item.texel_y, color: i_item.texel_color};
            r2_qx <= n_qx;
            r2_qy <= n_qy;
            r2_fx <= r1_tu[FW-1:0];
            r2_fy <= r1_tv[FW-1:0];
            r2_wr <= r1_wr;
            r3_x0 <= n_x0;
            r3_y0 <= n_y0;
            r3_fx <= r2_fx;
            r3_fy <= r2_fy;
            r3_wr <= r2_wr;
            r4_x0 <= r3_x0;
            r4_y0 <= r3_y0;
            r4_x1 <= n_x1;
            r4_y1 <= n_y1;
            r4_fx <= r3_fx;
            r4_fy <= r3_fy;
            r4_wr <= r3_wr;
        end
    end

    assign o_ctl = r4_ctl;
    assign o_x0  = r4_x0;
    assign o_x1  = r4_x1;
    assign o_y0  = r4_y0;
    assign o_y1  = r4_y1;
    assign o_fx  = r4_fx;
    assign o_fy  = r4_fy;
    assign o_wr  = r4_wr;

    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_ctl.valid && r4_ctl.sample) |->
            ((WW'(r4_x0) < i_width) && (HW'(r4_y0) < i_height)))
        else $error("wrapped texel index not below texture size");

    a_next_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_ctl.valid && r4_ctl.sample) |->
            ((r4_x1 == '0) || (r4_x1 == XW'(r4_x0 + XW'(1)))))
        else $error("right neighbor is neither next column nor wrapped");

    a_first_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_ctl.valid && r2_ctl.sample) |->
            (((WW+1)'(r2_qx) < (WW+1)'(two_w)) && ((HW+1)'(r2_qy) < (HW+1)'(two_h))))
        else $error("first reduction step left value above twice the size");

endmodule
`default_nettype wire

[design/tbts_filter.sv]
`default_nettype none
module tbts_filter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [tbts_pkg::FRAC_W-1:0]   i_fx,
    input  wire [tbts_pkg::FRAC_W-1:0]   i_fy,
    input  tbts_pkg::t_texel             i_tex00,
    input  tbts_pkg::t_texel             i_tex10,
    input  tbts_pkg::t_texel             i_tex01,
    input  tbts_pkg::t_texel             i_tex11,
    output logic                         o_valid,
    output tbts_pkg::t_out_item          o_res
);

    localparam int FW = tbts_pkg::FRAC_W;

    logic                r5_vld, r6_vld, r_out_vld;
    logic [FW-1:0]       r5_fx, r5_fy, r6_fy;
    tbts_pkg::t_out_item r6_top, r6_bot, r_out;
    tbts_pkg::t_out_item n_top, n_bot, n_out;

    // texel data arrives in the cycle after its address, in step with r5
    always_comb begin
        n_top.red   = tbts_pkg::lerp(i_tex00[23:16], i_tex10[23:16], r5_fx);
        n_top.green = tbts_pkg::lerp(i_tex00[15:8],  i_tex10[15:8],  r5_fx);
        n_top.blue  = tbts_pkg::lerp(i_tex00[7:0],   i_tex10[7:0],   r5_fx);
        n_bot.red   = tbts_pkg::lerp(i_tex01[23:16], i_tex11[23:16], r5_fx);
        n_bot.green = tbts_pkg::lerp(i_tex01[15:8],  i_tex11[15:8],  r5_fx);
        n_bot.blue  = tbts_pkg::lerp(i_tex01[7:0],   i_tex11[7:0],   r5_fx);
        n_out.red   = tbts_pkg::lerp(r6_top.red,   r6_bot.red,   r6_fy);
        n_out.green = tbts_pkg::lerp(r6_top.green, r6_bot.green, r6_fy);
        n_out.blue  = tbts_pkg::lerp(r6_top.blue,  r6_bot.blue,  r6_fy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld    <= i_valid;
            r6_vld    <= r5_vld;
            r_out_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_fx  <= i_fx;
            r5_fy  <= i_fy;
            r6_top <= n_top;
            r6_bot <= n_bot;
            r6_fy  <= r5_fy;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule
`default_nettype wire

[design/bilinear_texture_sampler_wrap.sv]
// A sample passes registers r1 to r4, the texture read with r5, then r6 and r_out.
// Throughput: one transaction (write or sample) per cycle; the texture sits in two
// identical copies, each with one write and two read ports, so four texels per cycle.
// A stalled output freezes the whole pipeline; writes produce no result.
// Reset (synchronous, active low) clears pipeline valids and sets width and height
// to 1024 clamped to the maximum; texture contents stay undefined until written.
`default_nettype none
module bilinear_texture_sampler_wrap #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  tbts_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output tbts_pkg::t_out_item                   o_out,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [tbts_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [tbts_pkg::CFG_W-1:0]             i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int W_RST = (MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    logic                 en;
    logic [WW-1:0]        r_w, n_w;
    logic [HW-1:0]        r_h, n_h;
    tbts_pkg::t_stage_ctl s4_ctl;
    tbts_pkg::t_wr        s4_wr;
    logic [XW-1:0]        s4_x0, s4_x1;
    logic [YW-1:0]        s4_y0, s4_y1;
    logic [tbts_pkg::FRAC_W-1:0] s4_fx, s4_fy;
    logic                 we;
    logic [AW-1:0]        waddr, a00, a10, a01, a11;
    tbts_pkg::t_texel     t00, t10, t01, t11;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // clamp sizes into 1..MAX when written
    always_comb begin
        if (i_cfg_data == '0) begin
            n_w = WW'(1);
            n_h = HW'(1);
        end else begin
            n_w = (32'(i_cfg_data) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            n_h = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(W_RST);
            r_h <= HW'(H_RST);
        end else if (i_cfg_valid) begin
            // drop writes to unknown registers
            unique case (i_cfg_index)
                tbts_pkg::CFG_TEX_WIDTH:  r_w <= n_w;
                tbts_pkg::CFG_TEX_HEIGHT: r_h <= n_h;
                default: ;
            endcase
        end
    end

    tbts_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_coord (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_item   (i_in),
        .i_width  (r_w),
        .i_height (r_h),
        .o_ctl    (s4_ctl),
        .o_x0     (s4_x0),
        .o_x1     (s4_x1),
        .o_y0     (s4_y0),
        .o_y1     (s4_y1),
        .o_fx     (s4_fx),
        .o_fy     (s4_fy),
        .o_wr     (s4_wr)
    );

    // writes land in the same stage as sample reads, which keeps transaction order
    assign we    = en && s4_ctl.valid && !s4_ctl.sample && s4_ctl.wr_en;
    assign waddr = AW'(AW'(s4_wr.y) * AW'(MAX_WIDTH) + AW'(s4_wr.x));
    assign a00   = AW'(AW'(s4_y0) * AW'(MAX_WIDTH) + AW'(s4_x0));
    assign a10   = AW'(AW'(s4_y0) * AW'(MAX_WIDTH) + AW'(s4_x1));
    assign a01   = AW'(AW'(s4_y1) * AW'(MAX_WIDTH) + AW'(s4_x0));
    assign a11   = AW'(AW'(s4_y1) * AW'(MAX_WIDTH) + AW'(s4_x1));

    tbts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_top (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (s4_wr.color),
        .i_raddr_a (a00),
        .i_raddr_b (a10),
        .o_rdata_a (t00),
        .o_rdata_b (t10)
    );

    tbts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_bot (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (s4_wr.color),
        .i_raddr_a (a01),
        .i_raddr_b (a11),
        .o_rdata_a (t01),
        .o_rdata_b (t11)
    );

    tbts_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s4_ctl.valid && s4_ctl.sample),
        .i_fx    (s4_fx),
        .i_fy    (s4_fy),
        .i_tex00 (t00),
        .i_tex10 (t10),
        .i_tex01 (t01),
        .i_tex11 (t11),
        .o_valid (o_out_valid),
        .o_res   (o_out)
    );

endmodule
`default_nettype wire
